@@ sv/spq_pkg.sv @@
// Package for the sorted priority queue: depth, widths, opcodes, entry record
// and ring-pointer helpers.
// No dependencies.
package spq_pkg;

  localparam int QueueDepth = 16;
  localparam int IdxW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int OccW       = 5;

  localparam logic [15:0] LangEn = 16'h656E;

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] payload;
    logic [15:0] lang;
    logic [2:0]  mode;
    logic [31:0] stamp;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic   ok;
    entry_t rec;
  } result_t;

  // Step back one slot around the ring.
  function automatic logic [IdxW-1:0] ring_prev(input logic [IdxW-1:0] p);
    ring_prev = (p == '0) ? IdxW'(QueueDepth - 1) : p - IdxW'(1);
  endfunction

  // Step forward one slot around the ring.
  function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] p);
    ring_next = (p == IdxW'(QueueDepth - 1)) ? '0 : p + IdxW'(1);
  endfunction

  // Slot just past the last held entry; count is below the depth here.
  function automatic logic [IdxW-1:0] ring_tail(input logic [IdxW-1:0] head,
                                                input logic [CntW-1:0] count);
    logic [IdxW:0] sum;
    sum = {1'b0, head} + {1'b0, count[IdxW-1:0]};
    if (sum >= (IdxW+1)'(QueueDepth)) begin
      sum = sum - (IdxW+1)'(QueueDepth);
    end
    ring_tail = sum[IdxW-1:0];
  endfunction

endpackage

@@ sv/sorted_priority_queue.sv @@
// Sorted priority queue of speech requests: ring buffer in one synchronous
// memory with insertion by shifting. Depends on spq_pkg.
//
// Clear and a rejected enqueue go straight to ST_DONE; dequeue/peek read the
// head in ST_HEAD; enqueue moves each held entry it passes (at most occupancy)
// up one slot in ST_INS_CMP, with one memory read and one write per entry.
// One beat in flight at a time; the next input beat is taken once the result
// sits in the output register. Reset empties the queue and loads "en" as the
// default language; the entry memory itself is not cleared.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic        payload_present_i,
  input  logic [15:0] payload_tag_i,
  input  logic [15:0] language_code_i,
  input  logic [7:0]  priority_req_i,
  input  logic [2:0]  voice_mode_i,
  input  logic [31:0] timestamp_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic [7:0]  head_priority_o,
  output logic [15:0] head_payload_o,
  output logic [15:0] head_language_o,
  output logic [2:0]  head_mode_o,
  output logic [31:0] head_time_o,
  output logic [4:0]  occupancy_o,
  output logic        is_full_o,
  output logic        is_empty_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_LAST,
    ST_HEAD,
    ST_DONE
  } state_e;

  // Control and working registers
  state_e            state_q,   state_d;
  op_e               op_q,      op_d;
  entry_t            fresh_q,   fresh_d;
  result_t           res_q,     res_d;
  logic [IdxW-1:0]   head_q,    head_d;
  logic [CntW-1:0]   count_q,   count_d;
  logic [IdxW-1:0]   pos_q,     pos_d;
  logic [CntW-1:0]   left_q,    left_d;
  logic [15:0]       dflt_lang_q;

  // Output register
  logic              out_valid_q, out_valid_d;
  result_t           out_res_q,   out_res_d;
  logic [OccW-1:0]   out_occ_q,   out_occ_d;
  logic              out_full_q,  out_full_d;
  logic              out_empty_q, out_empty_d;

  // Entry memory: one write port, one registered read port
  entry_t            mem_q [QueueDepth];
  entry_t            rd_data_q;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [IdxW-1:0]   mem_raddr;
  entry_t            mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[mem_raddr];
  end

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    fresh_d     = fresh_q;
    res_d       = res_q;
    head_d      = head_q;
    count_d     = count_q;
    pos_d       = pos_q;
    left_d      = left_q;
    out_res_d   = out_res_q;
    out_occ_d   = out_occ_q;
    out_full_d  = out_full_q;
    out_empty_d = out_empty_q;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = fresh_q;
    mem_raddr   = ring_prev(pos_q);

    // drop the output beat once it has been taken
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d          = op_e'(opcode_i);
          fresh_d.prio    = priority_req_i;
          fresh_d.payload = payload_tag_i;
          // substitute the default language when none is given
          fresh_d.lang    = (language_code_i != '0) ? language_code_i : dflt_lang_q;
          fresh_d.mode    = voice_mode_i;
          fresh_d.stamp   = timestamp_i;
          res_d           = '0;
          unique case (op_e'(opcode_i))
            OP_ENQ: begin
              if (!payload_present_i || count_q == CntW'(QueueDepth)) begin
                state_d = ST_DONE;
              end else begin
                pos_d  = ring_tail(head_q, count_q);
                left_d = count_q;
                // fetch the last held entry for the first compare
                mem_raddr = ring_prev(ring_tail(head_q, count_q));
                state_d   = (count_q == '0) ? ST_INS_LAST : ST_INS_CMP;
              end
            end
            OP_DEQ, OP_PEEK: begin
              if (count_q == '0) begin
                state_d = ST_DONE;
              end else begin
                mem_raddr = head_q;
                state_d   = ST_HEAD;
              end
            end
            OP_CLEAR: begin
              count_d  = '0;
              head_d   = '0;
              res_d.ok = 1'b1;
              state_d  = ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      ST_INS_CMP: begin
        if (fresh_q.prio < rd_data_q.prio) begin
          // move the held entry up one slot and look at the next one down
          mem_we    = 1'b1;
          mem_wdata = rd_data_q;
          pos_d     = ring_prev(pos_q);
          left_d    = left_q - CntW'(1);
          mem_raddr = ring_prev(ring_prev(pos_q));
          if (left_q == CntW'(1)) begin
            state_d = ST_INS_LAST;
          end
        end else begin
          mem_we   = 1'b1;
          count_d  = count_q + CntW'(1);
          res_d.ok = 1'b1;
          state_d  = ST_DONE;
        end
      end

      ST_INS_LAST: begin
        mem_we   = 1'b1;
        count_d  = count_q + CntW'(1);
        res_d.ok = 1'b1;
        state_d  = ST_DONE;
      end

      ST_HEAD: begin
        res_d.ok  = 1'b1;
        res_d.rec = rd_data_q;
        if (op_q == OP_DEQ) begin
          head_d  = ring_next(head_q);
          count_d = count_q - CntW'(1);
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          out_occ_d   = OccW'(count_q);
          out_full_d  = (count_q == CntW'(QueueDepth));
          out_empty_d = (count_q == '0);
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_ENQ;
      fresh_q     <= '0;
      res_q       <= '0;
      head_q      <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      left_q      <= '0;
      dflt_lang_q <= LangEn;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
      out_occ_q   <= '0;
      out_full_q  <= 1'b0;
      out_empty_q <= 1'b1;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      fresh_q     <= fresh_d;
      res_q       <= res_d;
      head_q      <= head_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      left_q      <= left_d;
      if (cfg_we_i) begin
        dflt_lang_q <= cfg_data_i;
      end
      out_valid_q <= out_valid_d;
      out_res_q   <= out_res_d;
      out_occ_q   <= out_occ_d;
      out_full_q  <= out_full_d;
      out_empty_q <= out_empty_d;
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign ok_o            = out_res_q.ok;
  assign head_priority_o = out_res_q.rec.prio;
  assign head_payload_o  = out_res_q.rec.payload;
  assign head_language_o = out_res_q.rec.lang;
  assign head_mode_o     = out_res_q.rec.mode;
  assign head_time_o     = out_res_q.rec.stamp;
  assign occupancy_o     = out_occ_q;
  assign is_full_o       = out_full_q;
  assign is_empty_o      = out_empty_q;

endmodule
